// ===== hw/rtl/stu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_pkg
// shared types and constants of the training-unit register file
// ----------------------------------------------------------------------------
package stu_pkg;

    // network shape and fixed-point format
    localparam int N_OUT     = 2;
    localparam int N_HID     = 4;
    localparam int N_IN      = 4;
    localparam int FRAC_BITS = 8;

    // storage depths of the word map
    localparam int ACT_DEPTH = 4;
    localparam int WD_DEPTH  = 16;
    localparam int L1_DEPTH  = 16;
    localparam int L2_DEPTH  = 8;
    localparam int OD_DEPTH  = 2;
    localparam int HD_DEPTH  = 4;

    localparam int IDX_W  = 4;
    localparam int ADDR_W = 7;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 31;
    localparam int CMD_W  = 5;

    localparam logic [ADDR_W-1:0] WORD_CMD  = 7'd28;
    localparam logic [ADDR_W-1:0] WORD_LOSS = 7'd76;

    // command word bits
    localparam logic [CMD_W-1:0] CMD_LOSS_D2  = 5'h01;
    localparam logic [CMD_W-1:0] CMD_D1       = 5'h02;
    localparam logic [CMD_W-1:0] CMD_UPD_L2   = 5'h04;
    localparam logic [CMD_W-1:0] CMD_UPD_L1   = 5'h08;
    localparam logic [CMD_W-1:0] CMD_LOSS_CLR = 5'h10;

    typedef enum logic [1:0] {
        CFG_ERR_LIMIT,
        CFG_DELTA_LIMIT,
        CFG_LR_SHIFT,
        CFG_LEAK_SHIFT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_MUL_SQ,
        OP_MUL_LEAK,
        OP_MUL_HID,
        OP_ROUND,
        OP_LOSS_ADD,
        OP_OUT_DELTA,
        OP_HID_DELTA,
        OP_UPD_L2,
        OP_UPD_L1,
        OP_LOSS_CLR
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D2_ERR,
        ST_D2_SQ,
        ST_D2_SQ_RND,
        ST_D2_LOSS,
        ST_D2_LEAK,
        ST_D2_LEAK_RND,
        ST_D2_OUT,
        ST_D1_MUL,
        ST_D1_RND,
        ST_D1_OUT,
        ST_UPD2,
        ST_UPD1,
        ST_CLR
    } t_state;

    // bus word as seen by the controller
    typedef struct packed {
        logic              accept;
        logic              write;
        logic [ADDR_W-1:0] address;
        logic [CMD_W-1:0]  bits;
    } t_req;

    // controller to datapath
    typedef struct packed {
        logic             busy;
        logic             bus_wr;
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
    } t_ctrl;

endpackage

// ===== hw/rtl/stu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_ctrl
// sequencer that walks the command bits and drives datapath operations
// ----------------------------------------------------------------------------
module stu_ctrl
    import stu_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_req  i_req,
    output t_ctrl o_ctrl
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [CMD_W-1:0] r_bits, n_bits;

    // first pending step in command order
    function automatic t_state pick(input logic [CMD_W-1:0] bits);
        t_state s;
        if ((bits & CMD_LOSS_D2) != '0) s = ST_D2_ERR;
        else if ((bits & CMD_D1) != '0) s = ST_D1_MUL;
        else if ((bits & CMD_UPD_L2) != '0) s = ST_UPD2;
        else if ((bits & CMD_UPD_L1) != '0) s = ST_UPD1;
        else if ((bits & CMD_LOSS_CLR) != '0) s = ST_CLR;
        else s = ST_IDLE;
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_bits  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_bits  <= n_bits;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_bits        = r_bits;
        o_ctrl.busy   = (r_state != ST_IDLE);
        o_ctrl.bus_wr = 1'b0;
        o_ctrl.op     = OP_NONE;
        o_ctrl.idx    = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.bus_wr = i_req.accept & i_req.write;
                if (i_req.accept && i_req.write && i_req.address == WORD_CMD) begin
                    n_bits  = i_req.bits;
                    n_idx   = '0;
                    n_state = pick(i_req.bits);
                end
            end
            ST_D2_ERR: begin
                o_ctrl.op = OP_ERR;
                n_state   = ST_D2_SQ;
            end
            ST_D2_SQ: begin
                o_ctrl.op = OP_MUL_SQ;
                n_state   = ST_D2_SQ_RND;
            end
            ST_D2_SQ_RND: begin
                o_ctrl.op = OP_ROUND;
                n_state   = ST_D2_LOSS;
            end
            ST_D2_LOSS: begin
                o_ctrl.op = OP_LOSS_ADD;
                n_state   = ST_D2_LEAK;
            end
            ST_D2_LEAK: begin
                o_ctrl.op = OP_MUL_LEAK;
                n_state   = ST_D2_LEAK_RND;
            end
            ST_D2_LEAK_RND: begin
                o_ctrl.op = OP_ROUND;
                n_state   = ST_D2_OUT;
            end
            ST_D2_OUT: begin
                o_ctrl.op = OP_OUT_DELTA;
                if (r_idx == IDX_W'(N_OUT - 1)) begin
                    n_idx   = '0;
                    n_state = pick(r_bits & ~CMD_LOSS_D2);
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_D2_ERR;
                end
            end
            ST_D1_MUL: begin
                o_ctrl.op = OP_MUL_HID;
                n_state   = ST_D1_RND;
            end
            ST_D1_RND: begin
                o_ctrl.op = OP_ROUND;
                n_state   = ST_D1_OUT;
            end
            ST_D1_OUT: begin
                o_ctrl.op = OP_HID_DELTA;
                if (r_idx == IDX_W'(N_HID - 1)) begin
                    n_idx   = '0;
                    n_state = pick(r_bits & (CMD_UPD_L2 | CMD_UPD_L1 | CMD_LOSS_CLR));
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_D1_MUL;
                end
            end
            ST_UPD2: begin
                o_ctrl.op = OP_UPD_L2;
                if (r_idx == IDX_W'(N_OUT * N_HID - 1)) begin
                    n_idx   = '0;
                    n_state = pick(r_bits & (CMD_UPD_L1 | CMD_LOSS_CLR));
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_UPD1: begin
                o_ctrl.op = OP_UPD_L1;
                if (r_idx == IDX_W'(N_HID * N_IN - 1)) begin
                    n_idx   = '0;
                    n_state = pick(r_bits & CMD_LOSS_CLR);
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_CLR: begin
                o_ctrl.op = OP_LOSS_CLR;
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/stu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_dp
// register windows, config registers and the shared multiply/round datapath
// ----------------------------------------------------------------------------
module stu_dp
    import stu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctrl                    i_ctrl,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic signed [DATA_W-1:0] i_write_data,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    output logic signed [DATA_W-1:0] o_read_data
);

    localparam int ACT_AW = $clog2(ACT_DEPTH);
    localparam int WD_AW  = $clog2(WD_DEPTH);
    localparam int L1_AW  = $clog2(L1_DEPTH);
    localparam int L2_AW  = $clog2(L2_DEPTH);
    localparam int OD_AW  = $clog2(OD_DEPTH);
    localparam int HD_AW  = $clog2(HD_DEPTH);

    localparam logic [DATA_W-1:0] FX_ONE   = DATA_W'(1) << FRAC_BITS;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [32:0] W_MIN    = -33'sd32768;
    localparam logic signed [32:0] W_MAX    = 33'sd32767;

    logic [CFG_W-1:0] r_err_limit, r_delta_limit;
    logic [4:0]       r_lr_shift;
    logic [3:0]       r_leak_shift;

    logic signed [DATA_W-1:0] r_act [ACT_DEPTH];
    logic signed [DATA_W-1:0] r_pre [ACT_DEPTH];
    logic signed [DATA_W-1:0] r_tgt [ACT_DEPTH];
    logic signed [DATA_W-1:0] r_wd  [WD_DEPTH];
    logic signed [DATA_W-1:0] r_l1  [L1_DEPTH];
    logic signed [DATA_W-1:0] r_l2  [L2_DEPTH];
    logic signed [DATA_W-1:0] r_od  [OD_DEPTH];
    logic signed [DATA_W-1:0] r_hd  [HD_DEPTH];
    logic signed [DATA_W-1:0] r_loss;

    logic signed [DATA_W-1:0] r_e;
    logic signed [63:0]       r_prod;
    logic signed [DATA_W-1:0] r_fx;

    logic [L1_AW-1:0]         l1_ridx;
    logic [L2_AW-1:0]         l2_ridx;
    logic signed [DATA_W-1:0] l1_rdata, l2_rdata;
    logic signed [DATA_W-1:0] act_rdata, pre_rdata, tgt_rdata, wd_rdata;
    logic signed [DATA_W-1:0] slope, mul_a, mul_b;
    logic signed [63:0]       prod_c, rnd_sum;
    logic signed [33:0]       err_diff;

    // clamp to -lim .. lim-1, lower bound first
    function automatic logic signed [DATA_W-1:0] clamp_lim(
        input logic signed [33:0] v,
        input logic [CFG_W-1:0]   lim
    );
        logic signed [33:0] lo, hi;
        lo = -$signed({3'b000, lim});
        hi = $signed({3'b000, lim}) - 34'sd1;
        if (v < lo) return lo[DATA_W-1:0];
        else if (v > hi) return hi[DATA_W-1:0];
        else return v[DATA_W-1:0];
    endfunction

    // w - (d >>> sh), saturated to int16
    function automatic logic signed [DATA_W-1:0] weight_step(
        input logic signed [DATA_W-1:0] w,
        input logic signed [DATA_W-1:0] d,
        input logic [4:0]               sh
    );
        logic signed [DATA_W-1:0] ds;
        logic signed [32:0]       r;
        ds = d >>> sh;
        r  = 33'(w) - 33'(ds);
        if (r < W_MIN) return DATA_W'(W_MIN);
        else if (r > W_MAX) return DATA_W'(W_MAX);
        else return DATA_W'(r);
    endfunction

    // one read index per weight window: sequencer while busy, bus otherwise
    assign l1_ridx   = i_ctrl.busy ? i_ctrl.idx[L1_AW-1:0] : i_address[L1_AW-1:0];
    assign l2_ridx   = i_ctrl.busy ? i_ctrl.idx[L2_AW-1:0] : i_address[L2_AW-1:0];
    assign l1_rdata  = r_l1[l1_ridx];
    assign l2_rdata  = r_l2[l2_ridx];
    assign act_rdata = r_act[i_ctrl.idx[ACT_AW-1:0]];
    assign pre_rdata = r_pre[i_ctrl.idx[ACT_AW-1:0]];
    assign tgt_rdata = r_tgt[i_ctrl.idx[ACT_AW-1:0]];
    assign wd_rdata  = r_wd[i_ctrl.idx[WD_AW-1:0]];

    assign err_diff = 34'(act_rdata) - 34'(tgt_rdata);
    assign slope    = pre_rdata[DATA_W-1] ? $signed(FX_ONE >> r_leak_shift)
                                          : $signed(FX_ONE);

    always_comb begin
        mul_a = r_e;
        mul_b = r_e;
        case (i_ctrl.op)
            OP_MUL_LEAK: mul_b = slope;
            OP_MUL_HID: begin
                mul_a = act_rdata;
                mul_b = slope;
            end
            default: ;
        endcase
    end

    assign prod_c  = mul_a * mul_b;
    assign rnd_sum = r_prod + RND_HALF;

    // bus read decode
    always_comb begin
        o_read_data = '0;
        if (i_address[6:4] == 3'b010) o_read_data = l1_rdata;
        else if (i_address[6:3] == 4'b0110) o_read_data = l2_rdata;
        else if (i_address[6:1] == 6'b100000) o_read_data = r_od[i_address[OD_AW-1:0]];
        else if (i_address[6:2] == 5'b10001) o_read_data = r_hd[i_address[HD_AW-1:0]];
        else if (i_address == WORD_LOSS) o_read_data = r_loss;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_limit   <= 31'd32768;
            r_delta_limit <= 31'd32768;
            r_lr_shift    <= 5'd4;
            r_leak_shift  <= 4'd3;
            r_act         <= '{default: '0};
            r_pre         <= '{default: '0};
            r_tgt         <= '{default: '0};
            r_wd          <= '{default: '0};
            r_l1          <= '{default: '0};
            r_l2          <= '{default: '0};
            r_od          <= '{default: '0};
            r_hd          <= '{default: '0};
            r_loss        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ERR_LIMIT:   r_err_limit   <= i_cfg_data;
                    CFG_DELTA_LIMIT: r_delta_limit <= i_cfg_data;
                    CFG_LR_SHIFT:    r_lr_shift    <= i_cfg_data[4:0];
                    CFG_LEAK_SHIFT:  r_leak_shift  <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_ctrl.bus_wr) begin
                if (i_address[6:2] == 5'd0) begin
                    r_act[i_address[ACT_AW-1:0]] <= i_write_data;
                end else if (i_address[6:2] == 5'd1) begin
                    r_pre[i_address[ACT_AW-1:0]] <= i_write_data;
                end else if (i_address[6:2] == 5'd2) begin
                    r_tgt[i_address[ACT_AW-1:0]] <= i_write_data;
                end else if (i_address >= 7'd12 && i_address <= 7'd27) begin
                    r_wd[WD_AW'(i_address - 7'd12)] <= i_write_data;
                end else if (i_address[6:4] == 3'b010) begin
                    r_l1[i_address[L1_AW-1:0]] <= i_write_data;
                end else if (i_address[6:3] == 4'b0110) begin
                    r_l2[i_address[L2_AW-1:0]] <= i_write_data;
                end
            end
            case (i_ctrl.op)
                OP_LOSS_ADD:  r_loss <= r_loss + r_fx;
                OP_OUT_DELTA: r_od[i_ctrl.idx[OD_AW-1:0]] <= clamp_lim(34'(r_fx), r_delta_limit);
                OP_HID_DELTA: r_hd[i_ctrl.idx[HD_AW-1:0]] <= clamp_lim(34'(r_fx), r_delta_limit);
                OP_UPD_L2:    r_l2[l2_ridx] <= weight_step(l2_rdata, wd_rdata, r_lr_shift);
                OP_UPD_L1:    r_l1[l1_ridx] <= weight_step(l1_rdata, wd_rdata, r_lr_shift);
                OP_LOSS_CLR:  r_loss <= '0;
                default: ;
            endcase
        end
    end

    // arithmetic pipeline registers, no reset needed
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op) inside
            OP_ERR:                           r_e    <= clamp_lim(err_diff, r_err_limit);
            OP_MUL_SQ, OP_MUL_LEAK, OP_MUL_HID: r_prod <= prod_c;
            OP_ROUND:                         r_fx   <= rnd_sum[FRAC_BITS+DATA_W-1:FRAC_BITS];
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/sgd_train_unit_registers.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgd_train_unit_registers
// word-addressed register file of a small fixed-point training unit
// ----------------------------------------------------------------------------
// read path: a read word is registered and shows on the output in the cycle after it is accepted
// throughput: reads and plain writes are taken one per cycle while o_stall is low
// a command word holds the input while the sequencer walks its steps on the single shared multiplier:
//   output neurons (error, square, round, loss, leak, round, delta), hidden neurons (multiply,
//   round, delta), then the layer-2 and layer-1 weights one by one and the loss clear
// reset: synchronous active low, clears windows, loss and output valid, config to defaults
// ----------------------------------------------------------------------------
module sgd_train_unit_registers
    import stu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input word channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_command,
    input  logic [ADDR_W-1:0]        i_address,
    input  logic signed [DATA_W-1:0] i_write_data,
    // read word channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_read_data,
    // config write port
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data
);

    t_req                     req;
    t_ctrl                    ctrl;
    logic                     accept;
    logic signed [DATA_W-1:0] dp_read_data;

    // output register: a finished read word waits here
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_read_data;

    // hold the input while a command runs, or while a read word is stuck
    assign o_stall = ctrl.busy | (r_out_valid & i_stall);
    assign accept  = i_valid & ~o_stall;

    assign req.accept  = accept;
    assign req.write   = i_command;
    assign req.address = i_address;
    assign req.bits    = i_write_data[CMD_W-1:0];

    stu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_ctrl  (ctrl)
    );

    stu_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (ctrl),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_read_data  (dp_read_data)
    );

    // read words load the output register, a taken word empties it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && !i_command) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_command) begin
            r_read_data <= dp_read_data;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;

endmodule

// ===== hw/rtl/stu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stu_checker
// port-level checks of the training-unit register file
// ----------------------------------------------------------------------------
module stu_checker
    import stu_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_stall,
    input logic                     i_command,
    input logic [ADDR_W-1:0]        i_address,
    input logic signed [DATA_W-1:0] i_write_data,
    input logic                     o_valid,
    input logic                     i_stall,
    input logic signed [DATA_W-1:0] o_read_data
);

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");

    // a stalled read word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data))
        else $error("stalled read word changed");

    // every accepted read gives a word next cycle
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_command |=> o_valid)
        else $error("accepted read gave no word");

    // a write never produces a word
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_command && !o_valid |=> !o_valid)
        else $error("write produced a word");

    // a command with work holds off the next input word
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_command && i_address == WORD_CMD &&
        i_write_data[CMD_W-1:0] != '0 |=> o_stall)
        else $error("command did not hold the input");

endmodule

bind sgd_train_unit_registers stu_checker u_stu_checker (.*);
